@@ sv/fpurs_pkg.sv @@
package fpurs_pkg;

   // field widths
   localparam int MAN_W      = 64;
   localparam int SEXP_W     = 16;
   localparam int KEXP_W     = 17;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 104;

   typedef logic [MAN_W-1:0]         man_type;
   typedef logic [SEXP_W-1:0]        sexp_type;
   typedef logic signed [KEXP_W-1:0] kexp_type;
   typedef logic [1:0]               tag_type;
   typedef logic [1:0]               cmp_type;

   // request codes
   localparam logic [3:0] REQ_PUSH     = 4'd0;
   localparam logic [3:0] REQ_POP      = 4'd1;
   localparam logic [3:0] REQ_READ_ST  = 4'd2;
   localparam logic [3:0] REQ_WRITE_ST = 4'd3;
   localparam logic [3:0] REQ_COMPARE  = 4'd4;
   localparam logic [3:0] REQ_MMX_RD   = 4'd5;
   localparam logic [3:0] REQ_MMX_WR   = 4'd6;
   localparam logic [3:0] REQ_EMMS     = 4'd7;
   localparam logic [3:0] REQ_STATUS   = 4'd8;
   localparam logic [3:0] REQ_CLEAR    = 4'd9;
   localparam logic [3:0] REQ_INIT     = 4'd10;

   // tag codes
   localparam tag_type TAG_VALID   = 2'd0;
   localparam tag_type TAG_ZERO    = 2'd1;
   localparam tag_type TAG_SPECIAL = 2'd2;
   localparam tag_type TAG_EMPTY   = 2'd3;

   // compare outcomes
   localparam cmp_type CMP_LT = 2'd0;
   localparam cmp_type CMP_EQ = 2'd1;
   localparam cmp_type CMP_GT = 2'd2;
   localparam cmp_type CMP_UN = 2'd3;

   // status word bits
   localparam sexp_type ST_IE         = 16'h0001;
   localparam sexp_type ST_SF         = 16'h0040;
   localparam sexp_type ST_C0         = 16'h0100;
   localparam sexp_type ST_C1         = 16'h0200;
   localparam sexp_type ST_C2         = 16'h0400;
   localparam sexp_type ST_C3         = 16'h4000;
   localparam sexp_type ST_CLEAR_MASK = 16'h80FF;

   localparam logic [14:0] EXP_MAX  = 15'h7FFF;
   localparam sexp_type    MMX_SEXP = 16'hFFFF;
   localparam man_type     INT_BIT  = 64'h8000_0000_0000_0000;

   function automatic tag_type classify(input man_type m, input sexp_type se);
      if (se[14:0] == EXP_MAX) return TAG_SPECIAL;
      if (m == '0) return TAG_ZERO;
      return TAG_VALID;
   endfunction

   function automatic logic is_nan(input man_type m, input sexp_type se);
      return (se[14:0] == EXP_MAX) && (m != INT_BIT);
   endfunction

   // a and b carry raw value plus normalized key (mantissa, exponent)
   function automatic cmp_type compare(input man_type am, input sexp_type ase,
                                       input man_type akm, input kexp_type ake,
                                       input man_type bm, input sexp_type bse,
                                       input man_type bkm, input kexp_type bke);
      logic    za;
      logic    zb;
      logic    na;
      logic    nb;
      cmp_type mag;
      za = (am == '0);
      zb = (bm == '0);
      na = ase[15];
      nb = bse[15];
      if (is_nan(am, ase) || is_nan(bm, bse)) return CMP_UN;
      if (za && zb) return CMP_EQ;
      if (za) return nb ? CMP_GT : CMP_LT;
      if (zb) return na ? CMP_LT : CMP_GT;
      if (na != nb) return na ? CMP_LT : CMP_GT;
      if (ake > bke) mag = CMP_GT;
      else if (ake < bke) mag = CMP_LT;
      else if (akm > bkm) mag = CMP_GT;
      else if (akm < bkm) mag = CMP_LT;
      else mag = CMP_EQ;
      if (na && mag == CMP_GT) return CMP_LT;
      if (na && mag == CMP_LT) return CMP_GT;
      return mag;
   endfunction

endpackage

@@ sv/fpurs_norm.sv @@
// two-stage leading-zero normalizer: coarse 16-bit step, then fine step
module fpurs_norm (
   input  logic                clock,
   input  logic                load1,
   input  logic                load2,
   input  fpurs_pkg::man_type  mantissa,
   input  logic [14:0]         exponent,
   output fpurs_pkg::man_type  key_man,
   output fpurs_pkg::kexp_type key_exp
);

   logic [1:0]          coarse_in;
   logic [1:0]          coarse_ff;
   fpurs_pkg::man_type  part_in;
   fpurs_pkg::man_type  part_ff;
   logic [14:0]         eff_in;
   logic [14:0]         eff_ff;
   logic [3:0]          fine_in;
   fpurs_pkg::man_type  key_man_in;
   fpurs_pkg::man_type  key_man_ff;
   fpurs_pkg::kexp_type key_exp_in;
   fpurs_pkg::kexp_type key_exp_ff;

   // stage 1: find leading nonzero 16-bit chunk
   always_comb begin
      if (mantissa[63:48] != '0) coarse_in = 2'd0;
      else if (mantissa[47:32] != '0) coarse_in = 2'd1;
      else if (mantissa[31:16] != '0) coarse_in = 2'd2;
      else coarse_in = 2'd3;
      case (coarse_in)
         2'd0: part_in = mantissa;
         2'd1: part_in = mantissa << 16;
         2'd2: part_in = mantissa << 32;
         default: part_in = mantissa << 48;
      endcase
      eff_in = (exponent == '0) ? 15'd1 : exponent;
   end

   // stage 2: leading zeros in the top chunk
   always_comb begin
      fine_in = '0;
      for (int i = 0; i < 16; i++) begin
         if (part_ff[48+i]) fine_in = 4'(15 - i);
      end
      key_man_in = part_ff << fine_in;
      key_exp_in = $signed({2'b00, eff_ff}) - $signed({11'b0, coarse_ff, fine_in});
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         coarse_ff <= coarse_in;
         part_ff   <= part_in;
         eff_ff    <= eff_in;
      end
      if (load2) begin
         key_man_ff <= key_man_in;
         key_exp_ff <= key_exp_in;
      end
   end

   assign key_man = key_man_ff;
   assign key_exp = key_exp_ff;

endmodule

@@ sv/fpu_register_stack.sv @@
// floating-point register stack: NUM_ENTRIES 80-bit entries rotating around TOP
//
// req channel: one request per transaction; req_tuser holds the request kind,
// req_tdata holds index, operand mantissa and operand sign/exponent
// rsp channel: exactly one result transaction per request, in request order;
// rsp_tuser is the ok flag, rsp_tdata holds the data read, the status word with
// TOP in bits 13:11, and the count of non-empty entries
//
// a request passes one input stage, then one normalizer stage that builds the
// operand's compare key, then the register-file access that updates the stack
// and loads the result register
// throughput is one transaction per cycle while results are taken; the register
// file has one read and one write address, so every request finishes its state
// update in the register-file access; when the result side stalls the pipeline
// stages keep filling, and the request side backs off only once all three stages
// hold a transaction; reset (and the init request) empties all tags, zeroes the
// stored entries, TOP and the status bits
module fpu_register_stack #(
   parameter int NUM_ENTRIES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [2:0] index, [66:3] value_mantissa, [82:67] value_sign_exp, [87:83] zero
   input  logic [fpurs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [3:0] req_type
   input  logic [3:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [63:0] data_mantissa, [79:64] data_sign_exp, [95:80] status_word,
   // [99:96] depth, [103:100] zero
   output logic [fpurs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] ok
   output logic                                rsp_tuser
);

   localparam int TW = $clog2(NUM_ENTRIES);
   localparam int DW = $clog2(NUM_ENTRIES + 1);
   localparam int SW = ((TW > 3) ? TW : 3) + 1;

   // stack storage
   fpurs_pkg::man_type  man_ff  [NUM_ENTRIES];
   fpurs_pkg::sexp_type sexp_ff [NUM_ENTRIES];
   fpurs_pkg::man_type  kman_ff [NUM_ENTRIES];
   fpurs_pkg::kexp_type kexp_ff [NUM_ENTRIES];
   fpurs_pkg::tag_type  tag_ff  [NUM_ENTRIES];
   fpurs_pkg::tag_type  tag_in  [NUM_ENTRIES];
   logic [TW-1:0]       top_ff;
   logic [TW-1:0]       top_in;
   fpurs_pkg::sexp_type stat_ff;
   fpurs_pkg::sexp_type stat_in;
   logic [DW-1:0]       depth_ff;
   logic [DW-1:0]       depth_in;

   // pipeline stages
   logic                s1_v_ff;
   logic                s1_v_in;
   logic [3:0]          s1_req_ff;
   logic [2:0]          s1_idx_ff;
   fpurs_pkg::man_type  s1_man_ff;
   fpurs_pkg::sexp_type s1_sexp_ff;
   logic                s2_v_ff;
   logic                s2_v_in;
   logic [3:0]          s2_req_ff;
   logic [2:0]          s2_idx_ff;
   fpurs_pkg::man_type  s2_man_ff;
   fpurs_pkg::sexp_type s2_sexp_ff;
   fpurs_pkg::man_type  op_kman;
   fpurs_pkg::kexp_type op_kexp;

   // result register
   logic                              rsp_v_ff;
   logic                              rsp_v_in;
   logic [fpurs_pkg::RSP_DATA_W-1:0]  rsp_data_ff;
   logic [fpurs_pkg::RSP_DATA_W-1:0]  rsp_data_in;
   logic                              rsp_ok_ff;

   // handshake chain
   logic req_acc;
   logic adv1;
   logic adv2;
   logic s2_rdy;
   logic exe_rdy;

   // execute-stage signals
   logic                ok;
   fpurs_pkg::man_type  dm;
   fpurs_pkg::sexp_type ds;
   logic                idx_ok;
   logic [SW-1:0]       phys_sum;
   logic [SW-1:0]       phys_wrap;
   logic [TW-1:0]       phys_idx;
   logic [TW-1:0]       push_addr;
   logic [TW-1:0]       pop_next;
   logic [TW-1:0]       rd_addr;
   fpurs_pkg::man_type  rd_man;
   fpurs_pkg::sexp_type rd_sexp;
   fpurs_pkg::man_type  rd_kman;
   fpurs_pkg::kexp_type rd_kexp;
   fpurs_pkg::tag_type  rd_tag;
   fpurs_pkg::tag_type  op_tag;
   fpurs_pkg::cmp_type  cmp;
   logic                wr_en;
   fpurs_pkg::sexp_type wr_sexp;
   logic                exe_init;
   fpurs_pkg::sexp_type status_word;
   logic [14:0]         norm_exp;

   // a stage moves on when the next one is empty or moving too
   assign exe_rdy    = !rsp_v_ff || rsp_tready;
   assign adv2       = s2_v_ff && exe_rdy;
   assign s2_rdy     = !s2_v_ff || adv2;
   assign adv1       = s1_v_ff && s2_rdy;
   assign req_tready = !s1_v_ff || adv1;
   assign req_acc    = req_tvalid && req_tready;

   assign s1_v_in  = req_acc ? 1'b1 : (adv1 ? 1'b0 : s1_v_ff);
   assign s2_v_in  = adv1 ? 1'b1 : (adv2 ? 1'b0 : s2_v_ff);
   assign rsp_v_in = adv2 ? 1'b1 : (rsp_tready ? 1'b0 : rsp_v_ff);

   // mmx writes store exponent all ones, so key them the same way
   assign norm_exp = (req_tuser == fpurs_pkg::REQ_MMX_WR) ?
                     fpurs_pkg::EXP_MAX : req_tdata[81:67];

   fpurs_norm u_norm (
      .clock    (clock),
      .load1    (req_acc),
      .load2    (adv1),
      .mantissa (req_tdata[66:3]),
      .exponent (norm_exp),
      .key_man  (op_kman),
      .key_exp  (op_kexp)
   );

   // stack addressing
   assign idx_ok    = (int'(s2_idx_ff) < NUM_ENTRIES);
   assign phys_sum  = SW'(top_ff) + SW'(s2_idx_ff);
   assign phys_wrap = (phys_sum >= SW'(NUM_ENTRIES)) ? phys_sum - SW'(NUM_ENTRIES) : phys_sum;
   assign phys_idx  = phys_wrap[TW-1:0];
   assign push_addr = (top_ff == '0) ? TW'(NUM_ENTRIES - 1) : top_ff - TW'(1);
   assign pop_next  = (top_ff == TW'(NUM_ENTRIES - 1)) ? '0 : top_ff + TW'(1);

   // single read address serves every request kind, and doubles as write address
   always_comb begin
      case (s2_req_ff)
         fpurs_pkg::REQ_PUSH:     rd_addr = push_addr;
         fpurs_pkg::REQ_READ_ST:  rd_addr = phys_idx;
         fpurs_pkg::REQ_WRITE_ST: rd_addr = phys_idx;
         fpurs_pkg::REQ_MMX_RD:   rd_addr = TW'(s2_idx_ff);
         fpurs_pkg::REQ_MMX_WR:   rd_addr = TW'(s2_idx_ff);
         default:                 rd_addr = top_ff;
      endcase
   end

   assign rd_man  = man_ff[rd_addr];
   assign rd_sexp = sexp_ff[rd_addr];
   assign rd_kman = kman_ff[rd_addr];
   assign rd_kexp = kexp_ff[rd_addr];
   assign rd_tag  = tag_ff[rd_addr];
   assign op_tag  = fpurs_pkg::classify(s2_man_ff, s2_sexp_ff);
   assign cmp     = fpurs_pkg::compare(rd_man, rd_sexp, rd_kman, rd_kexp,
                                       s2_man_ff, s2_sexp_ff, op_kman, op_kexp);

   // request execution
   always_comb begin
      ok       = 1'b0;
      dm       = '0;
      ds       = '0;
      stat_in  = stat_ff;
      top_in   = top_ff;
      depth_in = depth_ff;
      tag_in   = tag_ff;
      wr_en    = 1'b0;
      wr_sexp  = s2_sexp_ff;
      exe_init = 1'b0;
      case (s2_req_ff)
         fpurs_pkg::REQ_PUSH: begin
            if (rd_tag != fpurs_pkg::TAG_EMPTY) begin
               // stack overflow
               stat_in = stat_ff | fpurs_pkg::ST_IE | fpurs_pkg::ST_SF | fpurs_pkg::ST_C1;
            end else begin
               top_in            = push_addr;
               wr_en             = 1'b1;
               tag_in[push_addr] = op_tag;
               depth_in          = depth_ff + DW'(1);
               ok                = 1'b1;
            end
         end
         fpurs_pkg::REQ_POP: begin
            if (rd_tag == fpurs_pkg::TAG_EMPTY) begin
               // stack underflow
               stat_in = (stat_ff | fpurs_pkg::ST_IE | fpurs_pkg::ST_SF) & ~fpurs_pkg::ST_C1;
            end else begin
               dm             = rd_man;
               ds             = rd_sexp;
               tag_in[top_ff] = fpurs_pkg::TAG_EMPTY;
               top_in         = pop_next;
               depth_in       = depth_ff - DW'(1);
               ok             = 1'b1;
            end
         end
         fpurs_pkg::REQ_READ_ST: begin
            if (idx_ok && rd_tag != fpurs_pkg::TAG_EMPTY) begin
               dm = rd_man;
               ds = rd_sexp;
               ok = 1'b1;
            end
         end
         fpurs_pkg::REQ_WRITE_ST: begin
            if (idx_ok) begin
               wr_en            = 1'b1;
               tag_in[phys_idx] = op_tag;
               if (rd_tag == fpurs_pkg::TAG_EMPTY) depth_in = depth_ff + DW'(1);
               ok = 1'b1;
            end
         end
         fpurs_pkg::REQ_COMPARE: begin
            if (rd_tag == fpurs_pkg::TAG_EMPTY) begin
               stat_in = stat_ff | fpurs_pkg::ST_IE | fpurs_pkg::ST_SF;
            end else begin
               stat_in = stat_ff &
                         ~(fpurs_pkg::ST_C0 | fpurs_pkg::ST_C2 | fpurs_pkg::ST_C3);
               case (cmp)
                  fpurs_pkg::CMP_UN: stat_in = stat_in | fpurs_pkg::ST_C0 |
                     fpurs_pkg::ST_C2 | fpurs_pkg::ST_C3 | fpurs_pkg::ST_IE;
                  fpurs_pkg::CMP_LT: stat_in = stat_in | fpurs_pkg::ST_C0;
                  fpurs_pkg::CMP_EQ: stat_in = stat_in | fpurs_pkg::ST_C3;
                  default: ;
               endcase
               ok = 1'b1;
            end
         end
         fpurs_pkg::REQ_MMX_RD: begin
            if (idx_ok) begin
               dm = rd_man;
               ds = rd_sexp;
               ok = 1'b1;
            end
         end
         fpurs_pkg::REQ_MMX_WR: begin
            if (idx_ok) begin
               wr_en   = 1'b1;
               wr_sexp = fpurs_pkg::MMX_SEXP;
               for (int i = 0; i < NUM_ENTRIES; i++) tag_in[i] = fpurs_pkg::TAG_VALID;
               depth_in = DW'(NUM_ENTRIES);
               ok       = 1'b1;
            end
         end
         fpurs_pkg::REQ_EMMS: begin
            for (int i = 0; i < NUM_ENTRIES; i++) tag_in[i] = fpurs_pkg::TAG_EMPTY;
            depth_in = '0;
            ok       = 1'b1;
         end
         fpurs_pkg::REQ_STATUS: begin
            ok = 1'b1;
         end
         fpurs_pkg::REQ_CLEAR: begin
            stat_in = stat_ff & ~fpurs_pkg::ST_CLEAR_MASK;
            ok      = 1'b1;
         end
         fpurs_pkg::REQ_INIT: begin
            exe_init = 1'b1;
            for (int i = 0; i < NUM_ENTRIES; i++) tag_in[i] = fpurs_pkg::TAG_EMPTY;
            top_in   = '0;
            stat_in  = '0;
            depth_in = '0;
            ok       = 1'b1;
         end
         default: ;
      endcase
   end

   // TOP goes into bits 13:11 of the status word
   assign status_word = {stat_in[15:14], 3'(top_in), stat_in[10:0]};
   assign rsp_data_in = {4'b0, 4'(depth_in), status_word, ds, dm};

   // control state and entries that init clears
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
         top_ff   <= '0;
         stat_ff  <= '0;
         depth_ff <= '0;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            man_ff[i]  <= '0;
            sexp_ff[i] <= '0;
            tag_ff[i]  <= fpurs_pkg::TAG_EMPTY;
         end
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         rsp_v_ff <= rsp_v_in;
         if (adv2) begin
            top_ff   <= top_in;
            stat_ff  <= stat_in;
            depth_ff <= depth_in;
            tag_ff   <= tag_in;
            if (exe_init) begin
               for (int i = 0; i < NUM_ENTRIES; i++) begin
                  man_ff[i]  <= '0;
                  sexp_ff[i] <= '0;
               end
            end else if (wr_en) begin
               man_ff[rd_addr]  <= s2_man_ff;
               sexp_ff[rd_addr] <= wr_sexp;
            end
         end
      end
   end

   // payload: stage registers, compare keys, result
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_req_ff  <= req_tuser;
         s1_idx_ff  <= req_tdata[2:0];
         s1_man_ff  <= req_tdata[66:3];
         s1_sexp_ff <= req_tdata[82:67];
      end
      if (adv1) begin
         s2_req_ff  <= s1_req_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_man_ff  <= s1_man_ff;
         s2_sexp_ff <= s1_sexp_ff;
      end
      if (adv2) begin
         rsp_data_ff <= rsp_data_in;
         rsp_ok_ff   <= ok;
         // key only matters for nonzero entries, which always come with one
         if (wr_en && !exe_init) begin
            kman_ff[rd_addr] <= op_kman;
            kexp_ff[rd_addr] <= op_kexp;
         end
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

endmodule

@@ sv/fpurs_check.sv @@
module fpurs_check #(
   parameter int NUM_ENTRIES = 8
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [fpurs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic [3:0]                        req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [fpurs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tuser
);

   // pipeline comes out of reset empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // a request waiting for acceptance holds still
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("stalled request transaction changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result transaction changed");

   // failed requests return no data
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[79:0] == '0)
      else $error("failed transaction carries data");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (NUM_ENTRIES >= 16) || (int'(rsp_tdata[99:96]) <= NUM_ENTRIES))
      else $error("depth beyond stack size");

endmodule

bind fpu_register_stack fpurs_check #(.NUM_ENTRIES(NUM_ENTRIES)) u_check (.*);

@@ test/fpu_register_stack_tb.sv @@
`timescale 1ns / 1ps

// checks fpu_register_stack against a cycle-free predictor of the stack:
// requests are queued up front, driven on the falling edge, predicted when
// accepted, and each result transaction is checked against the oldest prediction
module fpu_register_stack_tb;

   localparam int STACK_DEPTH  = 8;
   localparam int RANDOM_ITEMS = 2000;
   localparam int PHASE_ITEMS  = 250;     // accepted requests per idling phase
   localparam int HOLD_FIRST   = 600;     // long result hold-offs start here
   localparam int HOLD_SECOND  = 1100;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 8;       // pipeline is 3 deep, leave some slack
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HISTORY_MAX  = 16;
   localparam int TOP_LSB      = 11;

   // idling phases
   localparam int PH_NONE     = 0;
   localparam int PH_SENDER   = 1;
   localparam int PH_RECEIVER = 2;
   localparam int PH_BOTH     = 3;

   // request codes the block does not know
   localparam logic [3:0] REQ_UNKNOWN_FIRST = 4'd11;
   localparam logic [3:0] REQ_UNKNOWN_LAST  = 4'd15;

   localparam fpurs_pkg::sexp_type TOP_FIELD = 16'h3800;
   localparam fpurs_pkg::sexp_type SIGN_BIT  = 16'h8000;
   localparam fpurs_pkg::sexp_type SEXP_ONE  = 16'h3FFF;   // exponent of 1.0
   localparam fpurs_pkg::sexp_type SEXP_TWO  = 16'h4000;   // exponent of 2.0

   typedef struct packed {
      logic [3:0]          kind;
      logic [2:0]          index;
      fpurs_pkg::man_type  man;
      fpurs_pkg::sexp_type sexp;
   } stack_req_type;

   typedef struct packed {
      logic                ok;
      fpurs_pkg::man_type  man;
      fpurs_pkg::sexp_type sexp;
      fpurs_pkg::sexp_type status;
      logic [3:0]          depth;
   } stack_rsp_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [fpurs_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [3:0]                       req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [fpurs_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;

   stack_req_type       pending_reqs[$];     // requests not yet offered
   stack_rsp_type       expected_rsps[$];    // predicted results in request order
   fpurs_pkg::man_type  seen_man[$];         // recently stored values, reused as operands
   fpurs_pkg::sexp_type seen_sexp[$];

   // predicted stack state
   fpurs_pkg::man_type  entry_man[STACK_DEPTH];
   fpurs_pkg::sexp_type entry_sexp[STACK_DEPTH];
   fpurs_pkg::tag_type  entry_tag[STACK_DEPTH];
   logic [2:0]          top_ptr;
   fpurs_pkg::sexp_type status_reg;

   int   accepted_count = 0;
   int   offered_count  = 0;     // requests put on the bus so far
   int   mismatch_count = 0;
   int   cycle_count    = 0;
   int   hold_left      = 0;
   int   holds_done     = 0;

   fpu_register_stack #(
      .NUM_ENTRIES(STACK_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic fpurs_pkg::tag_type value_tag(input fpurs_pkg::man_type m,
                                                    input fpurs_pkg::sexp_type se);
      if (se[14:0] == fpurs_pkg::EXP_MAX) return fpurs_pkg::TAG_SPECIAL;
      if (m == '0) return fpurs_pkg::TAG_ZERO;
      return fpurs_pkg::TAG_VALID;
   endfunction

   // infinity (integer bit alone) is ordered, every other max-exponent code is a nan
   function automatic logic is_unordered(input fpurs_pkg::man_type m,
                                         input fpurs_pkg::sexp_type se);
      return (se[14:0] == fpurs_pkg::EXP_MAX) && (m != fpurs_pkg::INT_BIT);
   endfunction

   // shift the mantissa up to its integer bit; exponent 0 counts as 1 (denormals)
   function automatic void normalize(input fpurs_pkg::man_type m,
                                     input fpurs_pkg::sexp_type se,
                                     output int e, output fpurs_pkg::man_type k);
      e = (se[14:0] == 15'd0) ? 1 : int'(se[14:0]);
      k = m;
      while (!k[fpurs_pkg::MAN_W-1]) begin
         k = k << 1;
         e = e - 1;
      end
   endfunction

   // exact ordering of two non-nan values, +0 and -0 equal
   function automatic fpurs_pkg::cmp_type value_order(input fpurs_pkg::man_type am,
                                                      input fpurs_pkg::sexp_type ase,
                                                      input fpurs_pkg::man_type bm,
                                                      input fpurs_pkg::sexp_type bse);
      int                 ea;
      int                 eb;
      fpurs_pkg::man_type ka;
      fpurs_pkg::man_type kb;
      fpurs_pkg::cmp_type mag;
      if (am == '0 && bm == '0) return fpurs_pkg::CMP_EQ;
      if (am == '0) return bse[15] ? fpurs_pkg::CMP_GT : fpurs_pkg::CMP_LT;
      if (bm == '0) return ase[15] ? fpurs_pkg::CMP_LT : fpurs_pkg::CMP_GT;
      if (ase[15] != bse[15]) return ase[15] ? fpurs_pkg::CMP_LT : fpurs_pkg::CMP_GT;
      normalize(am, ase, ea, ka);
      normalize(bm, bse, eb, kb);
      if (ea != eb) mag = (ea > eb) ? fpurs_pkg::CMP_GT : fpurs_pkg::CMP_LT;
      else if (ka != kb) mag = (ka > kb) ? fpurs_pkg::CMP_GT : fpurs_pkg::CMP_LT;
      else mag = fpurs_pkg::CMP_EQ;
      // negative values flip the magnitude order
      if (ase[15] && mag == fpurs_pkg::CMP_GT) return fpurs_pkg::CMP_LT;
      if (ase[15] && mag == fpurs_pkg::CMP_LT) return fpurs_pkg::CMP_GT;
      return mag;
   endfunction

   task automatic clear_stack();
      for (int i = 0; i < STACK_DEPTH; i++) begin
         entry_man[i]  = '0;
         entry_sexp[i] = '0;
         entry_tag[i]  = fpurs_pkg::TAG_EMPTY;
      end
      top_ptr    = '0;
      status_reg = '0;
   endtask

   // apply one accepted request to the stack and queue the result it gives
   task automatic predict_stack(input stack_req_type r);
      stack_rsp_type      e;
      logic [2:0]         slot;
      fpurs_pkg::cmp_type rel;
      e = '0;
      case (r.kind)
         fpurs_pkg::REQ_PUSH: begin
            slot = top_ptr - 3'd1;
            if (entry_tag[slot] != fpurs_pkg::TAG_EMPTY) begin
               // overflow: flags only
               status_reg = status_reg | fpurs_pkg::ST_IE | fpurs_pkg::ST_SF |
                            fpurs_pkg::ST_C1;
            end else begin
               top_ptr          = slot;
               entry_man[slot]  = r.man;
               entry_sexp[slot] = r.sexp;
               entry_tag[slot]  = value_tag(r.man, r.sexp);
               e.ok             = 1'b1;
            end
         end
         fpurs_pkg::REQ_POP: begin
            slot = top_ptr;
            if (entry_tag[slot] == fpurs_pkg::TAG_EMPTY) begin
               // underflow clears C1
               status_reg = (status_reg | fpurs_pkg::ST_IE | fpurs_pkg::ST_SF) &
                            ~fpurs_pkg::ST_C1;
            end else begin
               e.man           = entry_man[slot];
               e.sexp          = entry_sexp[slot];
               entry_tag[slot] = fpurs_pkg::TAG_EMPTY;
               top_ptr         = slot + 3'd1;
               e.ok            = 1'b1;
            end
         end
         fpurs_pkg::REQ_READ_ST: begin
            slot = top_ptr + r.index;
            if (entry_tag[slot] != fpurs_pkg::TAG_EMPTY) begin
               e.man  = entry_man[slot];
               e.sexp = entry_sexp[slot];
               e.ok   = 1'b1;
            end
         end
         fpurs_pkg::REQ_WRITE_ST: begin
            slot             = top_ptr + r.index;
            entry_man[slot]  = r.man;
            entry_sexp[slot] = r.sexp;
            entry_tag[slot]  = value_tag(r.man, r.sexp);
            e.ok             = 1'b1;
         end
         fpurs_pkg::REQ_COMPARE: begin
            slot = top_ptr;
            if (entry_tag[slot] == fpurs_pkg::TAG_EMPTY) begin
               status_reg = status_reg | fpurs_pkg::ST_IE | fpurs_pkg::ST_SF;
            end else begin
               status_reg = status_reg &
                            ~(fpurs_pkg::ST_C0 | fpurs_pkg::ST_C2 | fpurs_pkg::ST_C3);
               if (is_unordered(entry_man[slot], entry_sexp[slot]) ||
                   is_unordered(r.man, r.sexp)) begin
                  status_reg = status_reg | fpurs_pkg::ST_C0 | fpurs_pkg::ST_C2 |
                               fpurs_pkg::ST_C3 | fpurs_pkg::ST_IE;
               end else begin
                  rel = value_order(entry_man[slot], entry_sexp[slot], r.man, r.sexp);
                  if (rel == fpurs_pkg::CMP_LT) status_reg = status_reg | fpurs_pkg::ST_C0;
                  else if (rel == fpurs_pkg::CMP_EQ)
                     status_reg = status_reg | fpurs_pkg::ST_C3;
               end
               e.ok = 1'b1;
            end
         end
         fpurs_pkg::REQ_MMX_RD: begin
            // physical entry, tag ignored
            e.man  = entry_man[r.index];
            e.sexp = entry_sexp[r.index];
            e.ok   = 1'b1;
         end
         fpurs_pkg::REQ_MMX_WR: begin
            entry_man[r.index]  = r.man;
            entry_sexp[r.index] = fpurs_pkg::MMX_SEXP;
            for (int i = 0; i < STACK_DEPTH; i++) entry_tag[i] = fpurs_pkg::TAG_VALID;
            e.ok = 1'b1;
         end
         fpurs_pkg::REQ_EMMS: begin
            for (int i = 0; i < STACK_DEPTH; i++) entry_tag[i] = fpurs_pkg::TAG_EMPTY;
            e.ok = 1'b1;
         end
         fpurs_pkg::REQ_STATUS: begin
            e.ok = 1'b1;
         end
         fpurs_pkg::REQ_CLEAR: begin
            status_reg = status_reg & ~fpurs_pkg::ST_CLEAR_MASK;
            e.ok       = 1'b1;
         end
         fpurs_pkg::REQ_INIT: begin
            clear_stack();
            e.ok = 1'b1;
         end
         default: begin
            // unknown request: nothing changes, ok stays low
         end
      endcase
      e.status = (status_reg & ~TOP_FIELD) | (fpurs_pkg::sexp_type'(top_ptr) << TOP_LSB);
      for (int i = 0; i < STACK_DEPTH; i++)
         if (entry_tag[i] != fpurs_pkg::TAG_EMPTY) e.depth = e.depth + 4'd1;
      expected_rsps.push_back(e);
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic add_req(input logic [3:0] kind, input logic [2:0] index,
                          input fpurs_pkg::man_type m, input fpurs_pkg::sexp_type se);
      stack_req_type r;
      r.kind  = kind;
      r.index = index;
      r.man   = m;
      r.sexp  = se;
      pending_reqs.push_back(r);
      // remember stored values so compares can hit equality
      if (kind == fpurs_pkg::REQ_PUSH || kind == fpurs_pkg::REQ_WRITE_ST) begin
         seen_man.push_back(m);
         seen_sexp.push_back(se);
         if (seen_man.size() > HISTORY_MAX) begin
            void'(seen_man.pop_front());
            void'(seen_sexp.pop_front());
         end
      end
   endtask

   function automatic fpurs_pkg::man_type pick_mantissa();
      fpurs_pkg::man_type m;
      m = {$urandom, $urandom};
      case ($urandom_range(7))
         0: return '0;
         1: return fpurs_pkg::INT_BIT;
         2: return '1;
         3: return fpurs_pkg::man_type'(1) << $urandom_range(fpurs_pkg::MAN_W-1);
         4: return fpurs_pkg::INT_BIT | m;
         5: return m >> $urandom_range(fpurs_pkg::MAN_W-1);
         default: return m;
      endcase
   endfunction

   function automatic fpurs_pkg::sexp_type pick_sexp();
      logic [14:0] ex;
      ex = 15'($urandom);
      case ($urandom_range(5))
         0: ex = '0;
         1: ex = fpurs_pkg::EXP_MAX;
         2: ex = 15'd1;
         3: ex = 15'h3FF0 + 15'($urandom_range(31));
         4: ex = fpurs_pkg::EXP_MAX - 15'd1;
         default: ;
      endcase
      return {1'($urandom_range(1)), ex};
   endfunction

   // compare operand: often a stored value, sometimes in another encoding of it
   task automatic pick_operand(output fpurs_pkg::man_type m,
                               output fpurs_pkg::sexp_type se);
      int          pick;
      logic [14:0] ex;
      m  = pick_mantissa();
      se = pick_sexp();
      if (seen_man.size() != 0 && $urandom_range(99) < 50) begin
         pick = $urandom_range(seen_man.size() - 1);
         m    = seen_man[pick];
         se   = seen_sexp[pick];
         ex   = se[14:0];
         case ($urandom_range(3))
            0: begin
               // unnormal form of the same value
               if (m != '0 && !m[0] && ex >= 15'd1 && ex < fpurs_pkg::EXP_MAX - 15'd1) begin
                  m  = m >> 1;
                  se = {se[15], ex + 15'd1};
               end
            end
            1: if (ex == '0) se = {se[15], 15'd1};   // denormal exponent reads as 1
            2: if (m == '0) se = se ^ SIGN_BIT;       // +0 against -0
            default: ;
         endcase
      end
   endtask

   function automatic int current_phase();
      return (accepted_count / PHASE_ITEMS) % 4;
   endfunction

   function automatic logic sender_idles();
      case (current_phase())
         PH_SENDER: return $urandom_range(99) < 62;
         PH_BOTH:   return $urandom_range(99) < 35;
         default:   return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stalls();
      case (current_phase())
         PH_RECEIVER: return $urandom_range(99) < 62;
         PH_BOTH:     return $urandom_range(99) < 35;
         default:     return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------- request side

   // prediction runs on each accepted request transaction
   always @(posedge clock) begin : req_capture
      stack_req_type r;
      if (!reset && req_tvalid && req_tready) begin
         r.kind  = req_tuser;
         r.index = req_tdata[2:0];
         r.man   = req_tdata[66:3];
         r.sexp  = req_tdata[82:67];
         predict_stack(r);
         accepted_count = accepted_count + 1;
      end
   end

   // driver: a held request stays put until it is taken
   always @(negedge clock) begin : req_driver
      stack_req_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || accepted_count == offered_count) begin
         if (pending_reqs.size() != 0 && !sender_idles()) begin
            r = pending_reqs.pop_front();
            req_tuser  <= r.kind;
            req_tdata  <= {5'b0, r.sexp, r.man, r.index};
            req_tvalid <= 1'b1;
            offered_count = offered_count + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- result side

   // receiver: random stalls per phase, plus two long hold-offs that fill the pipe
   always @(negedge clock) begin : rsp_receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if ((holds_done == 0 && accepted_count >= HOLD_FIRST) ||
                   (holds_done == 1 && accepted_count >= HOLD_SECOND)) begin
         holds_done = holds_done + 1;
         hold_left  = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !receiver_stalls();
      end
   end

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("error at cycle %0d: %s is %h, predicted %h", cycle_count, field, got, want);
      mismatch_count = mismatch_count + 1;
   endtask

   // monitor: each result transaction against the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      stack_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unpredicted result, data", rsp_tdata[63:0], '0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_tuser !== want.ok)
               report_mismatch("ok", 64'(rsp_tuser), 64'(want.ok));
            if (rsp_tdata[63:0] !== want.man)
               report_mismatch("data_mantissa", rsp_tdata[63:0], want.man);
            if (rsp_tdata[79:64] !== want.sexp)
               report_mismatch("data_sign_exp", 64'(rsp_tdata[79:64]), 64'(want.sexp));
            if (rsp_tdata[95:80] !== want.status)
               report_mismatch("status_word", 64'(rsp_tdata[95:80]), 64'(want.status));
            if (rsp_tdata[99:96] !== want.depth)
               report_mismatch("depth", 64'(rsp_tdata[99:96]), 64'(want.depth));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : stimulus
      logic [3:0]          kind;
      fpurs_pkg::man_type  m;
      fpurs_pkg::sexp_type se;
      int                  w;
      clear_stack();

      // directed: empty-stack faults first
      add_req(fpurs_pkg::REQ_POP,      3'd0, '0, '0);              // pop underflow
      add_req(fpurs_pkg::REQ_READ_ST,  3'd0, '0, '0);              // read of an empty entry
      add_req(fpurs_pkg::REQ_COMPARE,  3'd0, fpurs_pkg::INT_BIT, SEXP_ONE); // empty top
      add_req(fpurs_pkg::REQ_PUSH,     3'd0, '0, SIGN_BIT);        // -0
      add_req(fpurs_pkg::REQ_COMPARE,  3'd0, '0, '0);              // -0 equals +0
      add_req(fpurs_pkg::REQ_PUSH,     3'd0, '1, {1'b0, fpurs_pkg::EXP_MAX}); // nan on stack
      add_req(fpurs_pkg::REQ_COMPARE,  3'd0, fpurs_pkg::INT_BIT, SEXP_ONE); // unordered
      add_req(fpurs_pkg::REQ_WRITE_ST, 3'd0, fpurs_pkg::INT_BIT, SEXP_ONE); // top is 1.0
      add_req(fpurs_pkg::REQ_COMPARE,  3'd0, fpurs_pkg::INT_BIT, SEXP_TWO); // less
      add_req(fpurs_pkg::REQ_COMPARE,  3'd0, 64'd1, 16'hFFFF);     // unordered operand
      add_req(fpurs_pkg::REQ_COMPARE,  3'd0, fpurs_pkg::INT_BIT, SEXP_ONE | SIGN_BIT);
      add_req(fpurs_pkg::REQ_COMPARE,  3'd0, fpurs_pkg::INT_BIT,
              {1'b0, fpurs_pkg::EXP_MAX});                         // infinity is ordered
      add_req(fpurs_pkg::REQ_COMPARE,  3'd0, fpurs_pkg::INT_BIT >> 1, SEXP_TWO); // equal
      add_req(fpurs_pkg::REQ_READ_ST,  3'd1, '0, '0);
      add_req(fpurs_pkg::REQ_READ_ST,  3'd7, '0, '0);
      add_req(fpurs_pkg::REQ_STATUS,   3'd0, '0, '0);
      add_req(fpurs_pkg::REQ_CLEAR,    3'd0, '0, '0);
      add_req(fpurs_pkg::REQ_MMX_WR,   3'd7, '1, '0);              // every tag goes valid
      add_req(fpurs_pkg::REQ_MMX_RD,   3'd7, '0, '0);
      add_req(fpurs_pkg::REQ_MMX_RD,   3'd3, '0, '0);
      add_req(fpurs_pkg::REQ_PUSH,     3'd0, 64'd1, 16'h0001);     // push overflow
      add_req(fpurs_pkg::REQ_POP,      3'd0, '0, '0);
      add_req(fpurs_pkg::REQ_EMMS,     3'd0, '0, '0);
      add_req(fpurs_pkg::REQ_WRITE_ST, 3'd5, 64'h0123_4567_89AB_CDEF, 16'h7FFE);
      add_req(REQ_UNKNOWN_FIRST, 3'd2, '1, '1);
      add_req(REQ_UNKNOWN_LAST,  3'd5, '1, '1);
      add_req(fpurs_pkg::REQ_INIT,     3'd0, '0, '0);

      // random mix, weighted toward push, pop, read and compare
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         w  = $urandom_range(99);
         m  = pick_mantissa();
         se = pick_sexp();
         if (w < 22)      kind = fpurs_pkg::REQ_PUSH;
         else if (w < 38) kind = fpurs_pkg::REQ_POP;
         else if (w < 50) kind = fpurs_pkg::REQ_READ_ST;
         else if (w < 58) kind = fpurs_pkg::REQ_WRITE_ST;
         else if (w < 74) kind = fpurs_pkg::REQ_COMPARE;
         else if (w < 80) kind = fpurs_pkg::REQ_MMX_RD;
         else if (w < 83) kind = fpurs_pkg::REQ_MMX_WR;
         else if (w < 87) kind = fpurs_pkg::REQ_EMMS;
         else if (w < 91) kind = fpurs_pkg::REQ_STATUS;
         else if (w < 95) kind = fpurs_pkg::REQ_CLEAR;
         else if (w < 97) kind = fpurs_pkg::REQ_INIT;
         else kind = 4'($urandom_range(REQ_UNKNOWN_LAST, REQ_UNKNOWN_FIRST));
         if (kind == fpurs_pkg::REQ_COMPARE) pick_operand(m, se);
         add_req(kind, 3'($urandom_range(7)), m, se);
      end

      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
